// ===== design/lkh_pkg.sv =====
// ============================================================================
// lkh_pkg: shared types and constants of the LRU-K page history table
// Command and status codes, payload structs and configuration constants.
// ============================================================================
package lkh_pkg;

    localparam int NUM_PAGES_DFLT     = 256;
    localparam int HISTORY_DEPTH_DFLT = 2;
    localparam int TIME_BITS_DFLT     = 48;

    localparam int CMD_W   = 3;
    localparam int PAGE_W  = 8;
    localparam int STAMP_W = 48;
    localparam int CAP_W   = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_ACCESS = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_VICTIM = 3'd3,
        CMD_QUERY  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_RANGE     = 2'd1,
        STATUS_NO_VICTIM = 2'd2
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [PAGE_W-1:0]  page_number;
        logic [STAMP_W-1:0] time_now;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [PAGE_W-1:0]  victim_page;
        logic [STAMP_W-1:0] victim_time;
        logic [STAMP_W-1:0] page_oldest_time;
        logic               page_mature;
    } out_t;

    // Broadcast from the top level to every cell while one command is in flight.
    typedef struct packed {
        logic             advance;
        cmd_t             cmd;
        logic [PAGE_W-1:0] page;
        logic             in_range;
        logic [CAP_W-1:0] capacity;
    } ctrl_t;

    // Token passed from cell to cell, at the default widths.
    typedef struct packed {
        logic                      valid;
        logic                      hit;
        logic [TIME_BITS_DFLT-1:0] best_time;
        logic [PAGE_W-1:0]         best_idx;
    } carry_dflt_t;

endpackage

// ===== design/lkh_apb_regs.sv =====
// ============================================================================
// lkh_apb_regs: configuration register file
// Holds the capacity register behind a simple APB-style slave port.
// ============================================================================
module lkh_apb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lkh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lkh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lkh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [lkh_pkg::CAP_W-1:0]          capacity_o
);

    logic [lkh_pkg::CAP_W-1:0] capacity_reg;
    logic [lkh_pkg::CAP_W-1:0] capacity_next;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == lkh_pkg::ADDR_CAPACITY);

    always_comb begin
        capacity_next = capacity_reg;
        if (wr_en) begin
            capacity_next = pwdata[lkh_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkh_pkg::CAP_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata = (paddr == lkh_pkg::ADDR_CAPACITY) ?
                    lkh_pkg::APB_DATA_W'(capacity_reg) : '0;
    assign capacity_o = capacity_reg;

endmodule

// ===== design/lkh_cell.sv =====
// ============================================================================
// lkh_cell: one page of the history chain
// Holds the access history of one page and folds it into the passing token.
// ============================================================================
module lkh_cell #(
    parameter int  INDEX         = 0,
    parameter int  IDX_W         = 8,
    parameter int  HISTORY_DEPTH = lkh_pkg::HISTORY_DEPTH_DFLT,
    parameter int  TIME_BITS     = lkh_pkg::TIME_BITS_DFLT,
    parameter type carry_t       = lkh_pkg::carry_dflt_t
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lkh_pkg::ctrl_t       ctrl_i,
    input  logic [TIME_BITS-1:0] time_i,
    input  carry_t               carry_i,
    output carry_t               carry_o
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    logic [TIME_BITS-1:0] slot_reg  [HISTORY_DEPTH];
    logic [TIME_BITS-1:0] slot_next [HISTORY_DEPTH];
    carry_t               carry_reg;
    carry_t               carry_next;
    logic [CNT_W-1:0]     fill_cnt;
    logic [TIME_BITS-1:0] oldest;
    logic                 mature;
    logic                 own;
    logic                 in_scope;

    // The oldest retained time is the slot just below the count of nonzero
    // slots, even when that particular slot happens to be zero.
    always_comb begin
        fill_cnt = '0;
        oldest   = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (slot_reg[i] != '0) begin
                fill_cnt = fill_cnt + CNT_W'(1);
            end
        end
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (fill_cnt == CNT_W'(i + 1)) begin
                oldest = slot_reg[i];
            end
        end
        mature = (fill_cnt == CNT_W'(HISTORY_DEPTH));
    end

    assign own      = ctrl_i.in_range && (int'(ctrl_i.page) == INDEX);
    assign in_scope = (INDEX < int'(ctrl_i.capacity));

    always_comb begin
        slot_next  = slot_reg;
        carry_next = carry_reg;
        if (ctrl_i.advance) begin
            carry_next = carry_i;
            if (carry_i.valid) begin
                case (ctrl_i.cmd)
                    lkh_pkg::CMD_INSERT: begin
                        if (own) begin
                            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                                slot_next[i] = '0;
                            end
                            slot_next[0] = time_i;
                        end
                    end
                    lkh_pkg::CMD_ACCESS: begin
                        if (own) begin
                            if (slot_reg[0] != '0) begin
                                for (int i = 1; i < HISTORY_DEPTH; i++) begin
                                    slot_next[i] = slot_reg[i-1];
                                end
                            end
                            slot_next[0] = time_i;
                        end
                    end
                    lkh_pkg::CMD_REMOVE: begin
                        if (own) begin
                            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                                slot_next[i] = '0;
                            end
                        end
                    end
                    lkh_pkg::CMD_QUERY: begin
                        // A query reuses the token's time and hit fields.
                        if (own) begin
                            carry_next.best_time = oldest;
                            carry_next.hit       = mature;
                        end
                    end
                    lkh_pkg::CMD_VICTIM: begin
                        if (in_scope && (oldest != '0) &&
                            (!carry_i.hit || (oldest < carry_i.best_time))) begin
                            carry_next.hit       = 1'b1;
                            carry_next.best_time = oldest;
                            carry_next.best_idx  = IDX_W'(INDEX);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                slot_reg[i] <= '0;
            end
            carry_reg <= '0;
        end else begin
            slot_reg  <= slot_next;
            carry_reg <= carry_next;
        end
    end

    assign carry_o = carry_reg;

endmodule

// ===== design/lru_k_page_history_table_core.sv =====
// ============================================================================
// lru_k_page_history_table_core: LRU-K page history table
// A chain of page cells swept by one command token at a time.
// ============================================================================
// Usage: commands arrive on the s_ valid/ready channel as one lkh_pkg::in_t
// transfer each, and every command yields exactly one lkh_pkg::out_t transfer
// on the m_ channel. The user must write the capacity register over the
// APB-style port only while no command is in flight; this is not enforced.
// Each accepted command launches a token into a chain of NUM_PAGES cells, one
// cell per page. The token moves one cell per cycle unless the chain holds, the
// addressed cell applies an update or reports its history, and a victim scan
// folds the running best page as it passes. The token passes through the cell
// registers to the end of the chain, where the result is loaded into the output
// register; the block becomes ready for the next command in the same cycle as
// m_valid rises, so it takes no new command while one is in flight.
// The result sits in an output register; while the receiver stalls, the token
// waits at the end of the chain and the cells hold.
// Reset clears all page histories, the token and the output valid flag, and
// sets capacity to 256. The block is ready in the first cycle after reset.
// ============================================================================
module lru_k_page_history_table_core #(
    parameter int NUM_PAGES     = lkh_pkg::NUM_PAGES_DFLT,
    parameter int HISTORY_DEPTH = lkh_pkg::HISTORY_DEPTH_DFLT,
    parameter int TIME_BITS     = lkh_pkg::TIME_BITS_DFLT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lkh_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lkh_pkg::out_t                  m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lkh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lkh_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lkh_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int CONV_W = (TIME_BITS < lkh_pkg::STAMP_W) ? TIME_BITS : lkh_pkg::STAMP_W;

    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [TIME_BITS-1:0] best_time;
        logic [IDX_W-1:0]     best_idx;
    } carry_t;

    logic [lkh_pkg::CAP_W-1:0]  capacity;
    logic                       busy_reg,     busy_next;
    logic                       launch_reg,   launch_next;
    lkh_pkg::cmd_t              cmd_reg,      cmd_next;
    logic [lkh_pkg::PAGE_W-1:0] page_reg,     page_next;
    logic [TIME_BITS-1:0]       time_reg,     time_next;
    logic                       in_range_reg, in_range_next;
    logic                       out_valid_reg, out_valid_next;
    lkh_pkg::out_t              out_reg,      out_next;
    lkh_pkg::out_t              result;
    lkh_pkg::ctrl_t             ctrl;
    carry_t                     chain [NUM_PAGES+1];
    carry_t                     tail;
    logic [NUM_PAGES:0]         tok_vec;
    logic                       accept;
    logic                       advance;
    logic                       load;
    logic                       page_cmd;

    lkh_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .capacity_o (capacity)
    );

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign tail    = chain[NUM_PAGES];
    // The chain holds only while a finished token cannot leave.
    assign advance = !(tail.valid && out_valid_reg && !m_ready);
    assign load    = tail.valid && (!out_valid_reg || m_ready);

    assign chain[0] = '{valid: launch_reg, hit: 1'b0, best_time: '0, best_idx: '0};

    always_comb begin
        ctrl.advance       = advance;
        ctrl.cmd           = cmd_reg;
        ctrl.page          = page_reg;
        ctrl.in_range      = in_range_reg;
        ctrl.capacity      = capacity;
    end

    for (genvar g = 0; g < NUM_PAGES; g++) begin : g_cell
        lkh_cell #(
            .INDEX         (g),
            .IDX_W         (IDX_W),
            .HISTORY_DEPTH (HISTORY_DEPTH),
            .TIME_BITS     (TIME_BITS),
            .carry_t       (carry_t)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl_i  (ctrl),
            .time_i  (time_reg),
            .carry_i (chain[g]),
            .carry_o (chain[g+1])
        );
    end

    for (genvar g = 0; g <= NUM_PAGES; g++) begin : g_tok
        assign tok_vec[g] = chain[g].valid;
    end

    always_comb begin
        busy_next     = busy_reg;
        launch_next   = launch_reg;
        cmd_next      = cmd_reg;
        page_next     = page_reg;
        time_next     = time_reg;
        in_range_next = in_range_reg;
        if (accept) begin
            busy_next     = 1'b1;
            launch_next   = 1'b1;
            cmd_next      = lkh_pkg::cmd_t'(s_data.cmd);
            page_next     = s_data.page_number;
            time_next     = TIME_BITS'(s_data.time_now[CONV_W-1:0]);
            in_range_next = ({1'b0, s_data.page_number} < capacity) &&
                            (int'(s_data.page_number) < NUM_PAGES);
        end else begin
            if (launch_reg && advance) begin
                launch_next = 1'b0;
            end
            if (load) begin
                busy_next = 1'b0;
            end
        end
    end

    assign page_cmd = (cmd_reg inside {lkh_pkg::CMD_INSERT, lkh_pkg::CMD_ACCESS,
                                       lkh_pkg::CMD_REMOVE, lkh_pkg::CMD_QUERY});

    always_comb begin
        result = '0;
        result.status = lkh_pkg::STATUS_DONE;
        if (page_cmd && !in_range_reg) begin
            result.status = lkh_pkg::STATUS_RANGE;
        end else if (cmd_reg == lkh_pkg::CMD_QUERY) begin
            result.page_oldest_time = lkh_pkg::STAMP_W'(tail.best_time[CONV_W-1:0]);
            result.page_mature      = tail.hit;
        end else if (cmd_reg == lkh_pkg::CMD_VICTIM) begin
            if (tail.hit) begin
                result.victim_page = lkh_pkg::PAGE_W'(tail.best_idx);
                result.victim_time = lkh_pkg::STAMP_W'(tail.best_time[CONV_W-1:0]);
            end else begin
                result.status = lkh_pkg::STATUS_NO_VICTIM;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_next       = result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        page_reg     <= page_next;
        time_reg     <= time_next;
        in_range_reg <= in_range_next;
        out_reg      <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_vec) <= 1)
        else $error("more than one command token in the cell chain");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (tok_vec == '0))
        else $error("token in the chain while the block is idle");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (!busy_reg && m_valid))
        else $error("finished transfer did not free the block");

    a_no_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == lkh_pkg::STATUS_NO_VICTIM)) |->
        ((m_data.victim_page == '0) && (m_data.victim_time == '0) && !m_data.page_mature))
        else $error("failed victim scan reports a victim");
`endif

endmodule
